// ----- hdl/rcfd_pkg.sv -----
// Shared constants, types and register codes of the remote-control frame decoder.
package rcfd_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int KEPT_BYTES  = 15;
  localparam int IDX_W       = $clog2(FRAME_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_DATA_W  = 11;

  localparam logic [10:0] CENTER_RESET    = 11'd1024;
  localparam logic [9:0]  DEAD_ZONE_RESET = 10'd5;
  localparam logic [12:0] CHANNEL_LIMIT   = 13'd8000;
  localparam logic [1:0]  SWITCH_MID      = 2'd3;
  localparam logic [1:0]  SWITCH_BAD      = 2'd0;

  typedef enum logic {
    CFG_CHANNEL_CENTER = 1'b0,
    CFG_DEAD_ZONE      = 1'b1
  } cfg_idx_e;

  typedef logic [KEPT_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic        push;
    logic        full;
  } q_wr_t;

  typedef struct packed {
    logic        valid;
    logic        pop;
  } q_rd_t;

endpackage

// ----- hdl/rcfd_byte_if.sv -----
// Byte stream channel into the decoder, and the record channel out of it.
interface rcfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface rcfd_rec_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] stick_ch0;
  logic signed [11:0] stick_ch1;
  logic signed [11:0] stick_ch2;
  logic signed [11:0] stick_ch3;
  logic [1:0]         switch_left;
  logic [1:0]         switch_right;
  logic signed [15:0] mouse_x;
  logic signed [15:0] mouse_y;
  logic signed [15:0] mouse_z;
  logic [7:0]         button_left;
  logic [7:0]         button_right;
  logic [7:0]         key_bits;

  modport source (output valid, output stick_ch0, output stick_ch1, output stick_ch2,
                  output stick_ch3, output switch_left, output switch_right,
                  output mouse_x, output mouse_y, output mouse_z, output button_left,
                  output button_right, output key_bits, input ready);
  modport sink   (input valid, input stick_ch0, input stick_ch1, input stick_ch2,
                  input stick_ch3, input switch_left, input switch_right,
                  input mouse_x, input mouse_y, input mouse_z, input button_left,
                  input button_right, input key_bits, output ready);
endinterface

// ----- hdl/rcfd_queue.sv -----
// Two-entry queue of complete frames between the byte front end and the decoder.
module rcfd_queue
  import rcfd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_frame_i,
  input  logic   pop_i,
  output q_wr_t  wr_o,
  output logic   valid_o,
  output frame_t head_o
);

  frame_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign wr_o.push = push_i;
  assign wr_o.full = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign head_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_frame_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.full |-> !push_i || pop_i)
    else $error("frame pushed into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("frame popped from empty queue");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- hdl/rcfd_front.sv -----
// Byte front end: tracks the frame position, stores the kept bytes, queues whole frames.
module rcfd_front
  import rcfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rcfd_byte_if.sink   byte_in_if,
  input  q_wr_t       q_wr_i,
  output logic        push_o,
  output frame_t      push_frame_o
);

  logic [IDX_W-1:0] byte_index_q, byte_index_d;
  logic [IDX_W-1:0] pos;
  frame_t           frame_q, frame_d;
  logic             accept, active;

  assign byte_in_if.ready = !q_wr_i.full;
  assign accept = byte_in_if.valid && byte_in_if.ready;

  // A start flag always opens a new frame; otherwise only count inside a frame.
  assign pos    = byte_in_if.frame_start ? '0 : byte_index_q;
  assign active = accept &&
                  (byte_in_if.frame_start || (byte_index_q < IDX_W'(FRAME_BYTES)));

  always_comb begin
    frame_d      = frame_q;
    byte_index_d = byte_index_q;
    push_o       = 1'b0;
    if (active) begin
      for (int k = 0; k < KEPT_BYTES; k++) begin
        if (pos == IDX_W'(k)) begin
          frame_d[k] = byte_in_if.rx_byte;
        end
      end
      byte_index_d = pos + 1'b1;
      push_o       = (pos == IDX_W'(FRAME_BYTES - 1));
    end
  end

  // Snapshot includes the byte landing this cycle.
  assign push_frame_o = frame_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= IDX_W'(FRAME_BYTES);
    end else begin
      byte_index_q <= byte_index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

endmodule

// ----- hdl/rcfd_back.sv -----
// Record decoder: centers and deadbands sticks, checks for errors, holds the output beat.
module rcfd_back
  import rcfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [10:0] channel_center_i,
  input  logic [9:0]  dead_zone_i,
  input  logic        q_valid_i,
  input  frame_t      q_head_i,
  output q_rd_t       q_rd_o,
  rcfd_rec_if.source  rec_out_if
);

  typedef struct packed {
    logic signed [11:0] ch0;
    logic signed [11:0] ch1;
    logic signed [11:0] ch2;
    logic signed [11:0] ch3;
    logic [1:0]         sw_l;
    logic [1:0]         sw_r;
    logic [15:0]        mx;
    logic [15:0]        my;
    logic [15:0]        mz;
    logic [7:0]         btn_l;
    logic [7:0]         btn_r;
    logic [7:0]         keys;
  } rec_t;

  function automatic logic [11:0] center_ch(input logic [10:0] raw,
                                            input logic [10:0] ctr,
                                            input logic [9:0]  dz);
    logic [11:0] v;
    logic [11:0] mag;
    v   = {1'b0, raw} - {1'b0, ctr};
    mag = v[11] ? (12'd0 - v) : v;
    return (mag < {2'b00, dz}) ? 12'd0 : v;
  endfunction

  function automatic logic over_limit(input logic [11:0] v);
    logic [11:0] mag;
    mag = v[11] ? (12'd0 - v) : v;
    return ({1'b0, mag} > CHANNEL_LIMIT);
  endfunction

  logic [47:0] bits;
  rec_t        dec, rec_q;
  logic        err;
  logic        out_valid_q;
  logic        pop;

  assign bits = {q_head_i[5], q_head_i[4], q_head_i[3],
                 q_head_i[2], q_head_i[1], q_head_i[0]};

  always_comb begin
    dec.ch0   = center_ch(bits[10:0],  channel_center_i, dead_zone_i);
    dec.ch1   = center_ch(bits[21:11], channel_center_i, dead_zone_i);
    dec.ch2   = center_ch(bits[32:22], channel_center_i, dead_zone_i);
    dec.ch3   = center_ch(bits[43:33], channel_center_i, dead_zone_i);
    dec.sw_l  = q_head_i[5][7:6];
    dec.sw_r  = q_head_i[5][5:4];
    dec.mx    = {q_head_i[7],  q_head_i[6]};
    dec.my    = {q_head_i[9],  q_head_i[8]};
    dec.mz    = {q_head_i[11], q_head_i[10]};
    dec.btn_l = q_head_i[12];
    dec.btn_r = q_head_i[13];
    dec.keys  = q_head_i[14];
    err = over_limit(dec.ch0) || over_limit(dec.ch1) || over_limit(dec.ch2) ||
          over_limit(dec.ch3) || (dec.sw_l == SWITCH_BAD) || (dec.sw_r == SWITCH_BAD);
    // Drop to the default record on error.
    if (err) begin
      dec      = '0;
      dec.sw_l = SWITCH_MID;
      dec.sw_r = SWITCH_MID;
    end
  end

  assign pop         = q_valid_i && (!out_valid_q || rec_out_if.ready);
  assign q_rd_o.valid = q_valid_i;
  assign q_rd_o.pop   = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (rec_out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rec_q <= dec;
    end
  end

  assign rec_out_if.valid        = out_valid_q;
  assign rec_out_if.stick_ch0    = rec_q.ch0;
  assign rec_out_if.stick_ch1    = rec_q.ch1;
  assign rec_out_if.stick_ch2    = rec_q.ch2;
  assign rec_out_if.stick_ch3    = rec_q.ch3;
  assign rec_out_if.switch_left  = rec_q.sw_l;
  assign rec_out_if.switch_right = rec_q.sw_r;
  assign rec_out_if.mouse_x      = rec_q.mx;
  assign rec_out_if.mouse_y      = rec_q.my;
  assign rec_out_if.mouse_z      = rec_q.mz;
  assign rec_out_if.button_left  = rec_q.btn_l;
  assign rec_out_if.button_right = rec_q.btn_r;
  assign rec_out_if.key_bits     = rec_q.keys;

  a_pop_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_q)
    else $error("popped frame not presented");
  a_switch_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (rec_q.sw_l != SWITCH_BAD) && (rec_q.sw_r != SWITCH_BAD))
    else $error("record carries a zero switch code");
  a_stick_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (rec_q.ch0 != 12'sh800) && (rec_q.ch1 != 12'sh800) &&
                    (rec_q.ch2 != 12'sh800) && (rec_q.ch3 != 12'sh800))
    else $error("stick channel out of centered range");

endmodule

// ----- hdl/remote_control_frame_decoder.sv -----
// Top level of the remote-control frame decoder.
// Takes one receiver byte per beat at up to one beat per clock; a byte with
// frame_start set opens a frame, and the 18th byte of the frame yields one
// decoded record on the record channel via the queue and the output register.
// Bytes outside a frame are taken and dropped. The front end stores bytes and
// hands whole frames to a two-entry queue; the back end decodes the queue head
// into a registered output beat. Byte intake stalls only when both queue entries
// are taken. The output register and the two queue entries hold three records,
// so a record consumer can hold off for two full frames before intake stalls.
// The user must write the channel_center and dead_zone registers through the
// config port only while no frame is in flight; the block does not enforce it.
module remote_control_frame_decoder
  import rcfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rcfd_byte_if.sink             byte_in_if,
  rcfd_rec_if.source            rec_out_if
);

  logic [10:0] channel_center_q;
  logic [9:0]  dead_zone_q;

  q_wr_t  q_wr;
  q_rd_t  q_rd;
  logic   push;
  frame_t push_frame;
  logic   q_valid;
  frame_t q_head;

  // Config registers; index selects which one takes the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_center_q <= CENTER_RESET;
      dead_zone_q      <= DEAD_ZONE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANNEL_CENTER: channel_center_q <= cfg_data_i[10:0];
        CFG_DEAD_ZONE:      dead_zone_q      <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Front: frame tracking and byte storage.
  rcfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_in_if   (byte_in_if),
    .q_wr_i       (q_wr),
    .push_o       (push),
    .push_frame_o (push_frame)
  );

  // Queue of complete frames.
  rcfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .pop_i        (q_rd.pop),
    .wr_o         (q_wr),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  // Back: decode and hold the output beat.
  rcfd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .channel_center_i (channel_center_q),
    .dead_zone_i      (dead_zone_q),
    .q_valid_i        (q_valid),
    .q_head_i         (q_head),
    .q_rd_o           (q_rd),
    .rec_out_if       (rec_out_if)
  );

endmodule

// ----- bench/rcfd_record_checker.sv -----
// Record checker: watches both channels and the register port, predicts and compares records.
`timescale 1ns / 1ps

module rcfd_record_checker
  import rcfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rcfd_byte_if                  byte_if,
  rcfd_rec_if                   rec_if,
  output int                    records_due_o,
  output int                    records_seen_o,
  output int                    flagged_o,
  output int                    mismatches_o
);

  typedef struct {
    logic [3:0][11:0] stick;
    logic [1:0]       sw_left;
    logic [1:0]       sw_right;
    logic [15:0]      mouse_x;
    logic [15:0]      mouse_y;
    logic [15:0]      mouse_z;
    logic [7:0]       btn_left;
    logic [7:0]       btn_right;
    logic [7:0]       keys;
    logic             flagged;
  } rc_record_t;

  logic [7:0]  frame_buf [KEPT_BYTES];
  int          fill_pos;
  logic [10:0] center_q;
  logic [9:0]  dead_q;
  rc_record_t  records_q[$];
  rc_record_t  want;
  int          mismatches;

  assign mismatches_o = mismatches;

  initial mismatches = 0;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, exp_val));
    end
  endtask

  // Decode the stored head of the frame with the current register values.
  function automatic rc_record_t decode_frame();
    rc_record_t  r;
    logic [10:0] raw [4];
    int          v;
    int          mag;
    logic        faulty;
    r = '{default: '0};
    faulty = 1'b0;
    raw[0] = {frame_buf[1][2:0], frame_buf[0]};
    raw[1] = {frame_buf[2][5:0], frame_buf[1][7:3]};
    raw[2] = {frame_buf[4][0], frame_buf[3], frame_buf[2][7:6]};
    raw[3] = {frame_buf[5][3:0], frame_buf[4][7:1]};
    for (int i = 0; i < 4; i++) begin
      v = int'(raw[i]) - int'(center_q);
      mag = (v < 0) ? -v : v;
      if (mag > int'(CHANNEL_LIMIT)) faulty = 1'b1;
      if (mag < int'(dead_q)) v = 0;
      r.stick[i] = v[11:0];
    end
    r.sw_left   = frame_buf[5][7:6];
    r.sw_right  = frame_buf[5][5:4];
    r.mouse_x   = {frame_buf[7], frame_buf[6]};
    r.mouse_y   = {frame_buf[9], frame_buf[8]};
    r.mouse_z   = {frame_buf[11], frame_buf[10]};
    r.btn_left  = frame_buf[12];
    r.btn_right = frame_buf[13];
    r.keys      = frame_buf[14];
    if (r.sw_left == SWITCH_BAD || r.sw_right == SWITCH_BAD) faulty = 1'b1;
    if (faulty) begin
      r = '{default: '0};
      r.sw_left  = SWITCH_MID;
      r.sw_right = SWITCH_MID;
      r.flagged  = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_pos = FRAME_BYTES;
      center_q = CENTER_RESET;
      dead_q   = DEAD_ZONE_RESET;
      records_q.delete();
      records_due_o  <= 0;
      records_seen_o <= 0;
      flagged_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CHANNEL_CENTER) center_q = cfg_data_i[10:0];
        else dead_q = cfg_data_i[9:0];
      end

      if (byte_if.valid && byte_if.ready) begin
        if (byte_if.frame_start) fill_pos = 0;
        if (fill_pos < FRAME_BYTES) begin
          if (fill_pos < KEPT_BYTES) frame_buf[fill_pos] = byte_if.rx_byte;
          fill_pos++;
          if (fill_pos == FRAME_BYTES) begin
            records_q.push_back(decode_frame());
            if (records_q[$].flagged) flagged_o <= flagged_o + 1;
          end
        end
      end

      if (rec_if.valid && rec_if.ready) begin
        records_seen_o <= records_seen_o + 1;
        if (records_q.size() == 0) begin
          report_mismatch("record beat with no completed frame behind it");
        end else begin
          want = records_q.pop_front();
          check_field("stick_ch0", 16'(rec_if.stick_ch0[11:0]), 16'(want.stick[0]));
          check_field("stick_ch1", 16'(rec_if.stick_ch1[11:0]), 16'(want.stick[1]));
          check_field("stick_ch2", 16'(rec_if.stick_ch2[11:0]), 16'(want.stick[2]));
          check_field("stick_ch3", 16'(rec_if.stick_ch3[11:0]), 16'(want.stick[3]));
          check_field("switch_left", 16'(rec_if.switch_left), 16'(want.sw_left));
          check_field("switch_right", 16'(rec_if.switch_right), 16'(want.sw_right));
          check_field("mouse_x", rec_if.mouse_x, want.mouse_x);
          check_field("mouse_y", rec_if.mouse_y, want.mouse_y);
          check_field("mouse_z", rec_if.mouse_z, want.mouse_z);
          check_field("button_left", 16'(rec_if.button_left), 16'(want.btn_left));
          check_field("button_right", 16'(rec_if.button_right), 16'(want.btn_right));
          check_field("key_bits", 16'(rec_if.key_bits), 16'(want.keys));
        end
      end

      records_due_o <= records_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: byte stimulus, record consumer, register writes, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
  import rcfd_pkg::*;

  // Long consumer hold-off: long enough to fill the frame queue and the
  // output register several times over, so the byte intake must stall.
  localparam int HOLD_CYCLES  = 200;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int QUIET_LIMIT  = 2000;
  // Settle time after the last record: covers the record decode path plus any
  // trailing bytes still moving through the front end.
  localparam int SETTLE       = 6;
  localparam int SEG_BYTES    = 112;
  localparam int SEG_FRAMES   = 6;
  localparam int NUM_SEGMENTS = 4;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rcfd_byte_if byte_if ();
  rcfd_rec_if  rec_if ();

  int records_due;
  int records_seen;
  int flagged;
  int mismatches;

  // Stimulus bookkeeping and knobs shared with the consumer process.
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          holds_asked  = 0;
  int          holds_done   = 0;
  int          quiet_cycles = 0;
  int          frame_bytes_sent = 0;
  int          full_frames  = 0;
  int          cut_frames   = 0;
  int          stray_bytes  = 0;
  int          settings     = 0;
  logic [10:0] cur_center   = CENTER_RESET;
  logic [9:0]  cur_dead     = DEAD_ZONE_RESET;
  logic [7:0]  frm [FRAME_BYTES];

  remote_control_frame_decoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .byte_in_if (byte_if),
    .rec_out_if (rec_if)
  );

  rcfd_record_checker u_rec_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .byte_if        (byte_if),
    .rec_if         (rec_if),
    .records_due_o  (records_due),
    .records_seen_o (records_seen),
    .flagged_o      (flagged),
    .mismatches_o   (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hang detection: count cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_if.valid && byte_if.ready) || (rec_if.valid && rec_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Record consumer: random back-pressure, plus a long hold-off on request.
  // The hold-off is counted here, so the byte sender keeps running meanwhile.
  initial begin
    rec_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_asked > holds_done) begin
        rec_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        rec_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  // Offer one byte; insert random idle cycles first, then hold until taken.
  task automatic send_byte(logic [7:0] data, logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.rx_byte     <= data;
    byte_if.frame_start <= start;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  // Send the first n bytes of the staged frame, start flag on byte 0.
  task automatic send_frame(int n);
    for (int i = 0; i < n; i++) send_byte(frm[i], i == 0);
    frame_bytes_sent += n;
    if (n == FRAME_BYTES) full_frames++;
    else cut_frames++;
  endtask

  // Bytes without a start flag after a finished frame: the block drops them.
  task automatic send_stray(int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
    stray_bytes += n;
  endtask

  // Pack channels and switches into bytes 0..5 of the staged frame.
  task automatic put_controls(logic [10:0] c0, logic [10:0] c1, logic [10:0] c2,
                              logic [10:0] c3, logic [1:0] sl, logic [1:0] sr);
    logic [47:0] w;
    w = {sl, sr, c3, c2, c1, c0};
    for (int i = 0; i < 6; i++) frm[i] = w[8*i +: 8];
  endtask

  // Bias channels toward the deadband edges around the current center and
  // toward the ends of the raw range.
  function automatic logic [10:0] pick_channel();
    int t;
    case ($urandom_range(7))
      0, 1: begin
        t = int'(cur_center) + int'($urandom_range(2 * cur_dead + 4)) - int'(cur_dead) - 2;
        if (t < 0) t = 0;
        if (t > 2047) t = 2047;
        return t[10:0];
      end
      2:       return 11'd0;
      3:       return 11'h7FF;
      default: return 11'($urandom);
    endcase
  endfunction

  // Mostly legal switch codes; the unused code 0 now and then.
  function automatic logic [1:0] pick_switch();
    if ($urandom_range(9) == 0) return SWITCH_BAD;
    return 2'($urandom_range(3, 1));
  endfunction

  task automatic fill_frame();
    put_controls(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                 pick_switch(), pick_switch());
    for (int i = 6; i < FRAME_BYTES; i++) frm[i] = 8'($urandom);
  endtask

  // Drop valid and wait until every completed frame has come back as a record,
  // then give the front end time to finish with trailing bytes.
  task automatic drain_all();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (records_due != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back cycles while the block is idle.
  task automatic set_config(logic [10:0] center, logic [9:0] dead);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_CHANNEL_CENTER;
    cfg_data <= CFG_DATA_W'(center);
    @(posedge clk_i);
    cfg_idx  <= CFG_DEAD_ZONE;
    cfg_data <= CFG_DATA_W'(dead);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_center = center;
    cur_dead   = dead;
    settings++;
  endtask

  initial begin
    int   seg_bytes;
    int   seg_frames;
    int   n;
    int   pick;
    logic open_frame;
    logic paused;

    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_CHANNEL_CENTER;
    cfg_data            <= '0;
    byte_if.valid       <= 1'b0;
    byte_if.rx_byte     <= '0;
    byte_if.frame_start <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part, reset register values (center 1024, deadband 5) ----
    // Bytes before any start flag: ignored.
    send_stray(3);
    // Raw range ends, deadband edge kept (+5), switches up/down, mouse extremes.
    put_controls(11'd0, 11'h7FF, 11'd1024, 11'd1029, 2'd1, 2'd2);
    frm[6]  = 8'h00; frm[7]  = 8'h80; frm[8]  = 8'hFF; frm[9]  = 8'h7F;
    frm[10] = 8'hFF; frm[11] = 8'hFF; frm[12] = 8'hFF; frm[13] = 8'hFF;
    frm[14] = 8'hA5; frm[15] = 8'hFF; frm[16] = 8'h00; frm[17] = 8'hFF;
    send_frame(FRAME_BYTES);
    // Deadband edges: magnitude 4 zeroed, magnitude 5 kept; switches mid; zero tail.
    put_controls(11'd1020, 11'd1028, 11'd1019, 11'd1024, 2'd3, 2'd3);
    for (int i = 6; i < FRAME_BYTES; i++) frm[i] = 8'h00;
    send_frame(FRAME_BYTES);
    // Trailing bytes after a finished frame: ignored.
    send_stray(4);
    // Unused switch code on the left, then on the right: default record.
    fill_frame();
    put_controls(11'h7FF, 11'd0, 11'd1500, 11'd3, SWITCH_BAD, 2'd1);
    send_frame(FRAME_BYTES);
    fill_frame();
    put_controls(11'd500, 11'd1024, 11'h7FF, 11'd0, 2'd2, SWITCH_BAD);
    send_frame(FRAME_BYTES);
    // Start flag mid-frame, then on the last byte position: partial frames dropped.
    fill_frame();
    send_frame(9);
    fill_frame();
    send_frame(FRAME_BYTES - 1);
    fill_frame();
    send_frame(FRAME_BYTES);
    drain_all();

    // ---- Random part: four register settings, three traffic shapes ----
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      case (seg)
        0: begin
          set_config(11'd0, 10'd0);
          src_idle_pct = 30;
          snk_idle_pct = 88;
        end
        1: begin
          set_config(11'h7FF, 10'h3FF);
          src_idle_pct = 88;
          snk_idle_pct = 30;
        end
        2: begin
          set_config(11'($urandom), 10'($urandom_range(63)));
          src_idle_pct = 0;
          snk_idle_pct = 0;
          // Stall the consumer while bytes keep coming back to back.
          holds_asked++;
        end
        default: begin
          set_config(11'($urandom_range(1100, 950)), 10'($urandom));
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase

      seg_bytes  = 0;
      seg_frames = 0;
      open_frame = 1'b0;
      paused     = 1'b0;
      while (seg_bytes < SEG_BYTES || seg_frames < SEG_FRAMES || open_frame) begin
        // Once, halfway through, hold the sender until all records are back.
        if (seg == 1 && !paused && seg_bytes >= SEG_BYTES / 2) begin
          drain_all();
          paused = 1'b1;
        end
        pick = $urandom_range(9);
        fill_frame();
        if (pick >= 8 && seg_frames < SEG_FRAMES + 4) begin
          n = $urandom_range(FRAME_BYTES - 1, 1);
          send_frame(n);
          seg_bytes += n;
          open_frame = 1'b1;
        end else begin
          send_frame(FRAME_BYTES);
          seg_bytes += FRAME_BYTES;
          seg_frames++;
          open_frame = 1'b0;
          if (pick == 7) send_stray($urandom_range(5, 1));
        end
      end
      drain_all();
    end

    $display("covered %0d frame bytes: %0d full frames, %0d cut short, %0d stray bytes",
             frame_bytes_sent, full_frames, cut_frames, stray_bytes);
    $display("checked %0d records (%0d default records) over %0d register settings",
             records_seen, flagged, settings + 1);
    if (mismatches == 0 && records_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
